[design/tmtw_pkg.sv]
`default_nettype none
package tmtw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] INIT_ATTR    = 8'h07;

    typedef struct packed {
        logic latch;
        logic cnt_clr;
        logic cnt_inc;
        logic wr_all;
        logic init_fill;
        logic wr_row;
        logic scroll_commit;
        logic wr_put;
        logic newline;
        logic rd_en;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic op_put;
        logic op_clear;
        logic op_read;
        logic need_scroll;
        logic is_newline;
        logic cnt_last_all;
        logic cnt_last_row;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[design/tmtw_ctrl.sv]
`default_nettype none
module tmtw_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire tmtw_pkg::t_stat i_stat,
    output logic                o_ready,
    output tmtw_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCROLL,
        S_PUT,
        S_FILL,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_all    = 1'b1;
                o_cmd.init_fill = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_stat.cnt_last_all) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.cnt_clr = 1'b1;
                if (i_stat.op_put) begin
                    n_state = i_stat.need_scroll ? S_SCROLL : S_PUT;
                end else if (i_stat.op_clear) begin
                    n_state = S_FILL;
                end else if (i_stat.op_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                o_cmd.wr_row  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt_last_row) begin
                    o_cmd.scroll_commit = 1'b1;
                    n_state             = S_PUT;
                end
            end
            S_PUT: begin
                if (i_stat.is_newline) begin
                    o_cmd.newline = 1'b1;
                end else begin
                    o_cmd.wr_put = 1'b1;
                end
                n_state = S_DONE;
            end
            S_FILL: begin
                o_cmd.wr_all  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt_last_all) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[design/tmtw_datapath.sv]
`default_nettype none
module tmtw_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tmtw_pkg::t_cmd             i_cmd,
    output tmtw_pkg::t_stat                 o_stat,
    input  wire logic [7:0]                 i_text_color,
    input  wire logic [1:0]                 i_operation,
    input  wire logic [7:0]                 i_char_code,
    input  wire logic [7:0]                 i_fill_color,
    input  wire logic [tmtw_pkg::COL_W-1:0] i_column,
    input  wire logic [tmtw_pkg::ROW_W-1:0] i_row,
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output logic [15:0]                     o_cell_entry,
    output logic [tmtw_pkg::COL_W-1:0]      o_cursor_column,
    output logic [tmtw_pkg::ROW_W-1:0]      o_cursor_row
);

    localparam int COL_W  = tmtw_pkg::COL_W;
    localparam int ROW_W  = tmtw_pkg::ROW_W;
    localparam int ADDR_W = tmtw_pkg::ADDR_W;

    logic [15:0]       mem [tmtw_pkg::CELLS];
    logic [15:0]       r_rdata;

    logic [1:0]        r_op;
    logic [7:0]        r_char;
    logic [7:0]        r_fill;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [ROW_W-1:0]  r_base;
    logic [ADDR_W-1:0] r_cnt;

    logic              r_out_valid;
    logic [15:0]       r_cell_entry;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;

    logic              in_range;
    logic [ROW_W-1:0]  lrow;
    logic [COL_W-1:0]  lcol;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W:0]    prow_sum;
    logic [ROW_W:0]    prow;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] row_addr;
    logic [COL_W:0]    col_inc;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;

    assign in_range = (r_col < COL_W'(tmtw_pkg::COLUMNS)) && (r_row < ROW_W'(tmtw_pkg::ROWS));
    assign put_col  = (r_cur_col >= COL_W'(tmtw_pkg::COLUMNS)) ? '0 : r_cur_col;

    always_comb begin
        if (r_op == tmtw_pkg::OP_READ) begin
            lrow = in_range ? r_row : '0;
            lcol = in_range ? r_col : '0;
        end else begin
            lrow = r_cur_row;
            lcol = put_col;
        end
        prow_sum = {1'b0, lrow} + {1'b0, r_base};
        if (prow_sum >= (ROW_W + 1)'(tmtw_pkg::ROWS)) begin
            prow = prow_sum - (ROW_W + 1)'(tmtw_pkg::ROWS);
        end else begin
            prow = prow_sum;
        end
        cell_addr = ADDR_W'(prow) * ADDR_W'(tmtw_pkg::COLUMNS) + ADDR_W'(lcol);
        row_addr  = ADDR_W'(r_base) * ADDR_W'(tmtw_pkg::COLUMNS) + r_cnt;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_cnt;
        wdata = {i_text_color, tmtw_pkg::SPACE_CHAR};
        if (i_cmd.wr_all) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = {(i_cmd.init_fill ? tmtw_pkg::INIT_ATTR : r_fill), tmtw_pkg::SPACE_CHAR};
        end else if (i_cmd.wr_row) begin
            we    = 1'b1;
            waddr = row_addr;
            wdata = {i_text_color, tmtw_pkg::SPACE_CHAR};
        end else if (i_cmd.wr_put) begin
            we    = 1'b1;
            waddr = cell_addr;
            wdata = {i_text_color, r_char};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[cell_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_operation;
            r_char <= i_char_code;
            r_fill <= i_fill_color;
            r_col  <= i_column;
            r_row  <= i_row;
        end
        if (i_cmd.load_out) begin
            r_cell_entry <= (r_op == tmtw_pkg::OP_READ && in_range) ? r_rdata : 16'h0000;
            r_out_col    <= r_cur_col;
            r_out_row    <= r_cur_row;
        end
    end

    assign col_inc = {1'b0, put_col} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.scroll_commit) begin
                r_cur_row <= ROW_W'(tmtw_pkg::ROWS - 1);
                r_base    <= (r_base == ROW_W'(tmtw_pkg::ROWS - 1)) ? '0 : r_base + 1'b1;
            end else if (i_cmd.newline) begin
                r_cur_col <= '0;
                r_cur_row <= r_cur_row + 1'b1;
            end else if (i_cmd.wr_put) begin
                if (col_inc >= (COL_W + 1)'(tmtw_pkg::COLUMNS)) begin
                    r_cur_col <= '0;
                    r_cur_row <= r_cur_row + 1'b1;
                end else begin
                    r_cur_col <= col_inc[COL_W-1:0];
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.op_put       = (r_op == tmtw_pkg::OP_PUT);
    assign o_stat.op_clear     = (r_op == tmtw_pkg::OP_CLEAR);
    assign o_stat.op_read      = (r_op == tmtw_pkg::OP_READ);
    assign o_stat.need_scroll  = (r_cur_row >= ROW_W'(tmtw_pkg::ROWS));
    assign o_stat.is_newline   = (r_char == tmtw_pkg::NEWLINE_CHAR);
    assign o_stat.cnt_last_all = (r_cnt == ADDR_W'(tmtw_pkg::CELLS - 1));
    assign o_stat.cnt_last_row = (r_cnt == ADDR_W'(tmtw_pkg::COLUMNS - 1));
    assign o_stat.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_cell_entry    = r_cell_entry;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;

endmodule
`default_nettype wire

[design/text_mode_terminal_writer.sv]
// Sequence: a put is dispatched and then written, after a scroll when one is pending (last
//   row cleared through a rotating row base); a read is dispatched and then read from the
//   screen memory; a clear writes the whole screen, one cell written per cycle.
// Input: one item at a time; the next word is taken once the result is in the output
//   register. The 2000-cell screen memory has a single write port.
// Reset: synchronous, active low; a pass then writes 0x0720 to every cell, input stalled
//   meanwhile; configuration writes are taken throughout.
`default_nettype none
module text_mode_terminal_writer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_operation,
    input  wire logic [7:0]                 i_char_code,
    input  wire logic [7:0]                 i_fill_color,
    input  wire logic [tmtw_pkg::COL_W-1:0] i_column,
    input  wire logic [tmtw_pkg::ROW_W-1:0] i_row,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [15:0]                     o_cell_entry,
    output logic [tmtw_pkg::COL_W-1:0]      o_cursor_column,
    output logic [tmtw_pkg::ROW_W-1:0]      o_cursor_row
);

    logic [7:0]      r_text_color;
    logic            ready;
    tmtw_pkg::t_cmd  cmd;
    tmtw_pkg::t_stat stat;

    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? 32'h0 : {24'h0, r_text_color};
    assign o_in_stall = !ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tmtw_pkg::INIT_ATTR;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_text_color <= pwdata[7:0];
        end
    end

    tmtw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    tmtw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_text_color    (r_text_color),
        .i_operation     (i_operation),
        .i_char_code     (i_char_code),
        .i_fill_color    (i_fill_color),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_cell_entry    (o_cell_entry),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row)
    );

endmodule
`default_nettype wire
